[hdl/lfc_pkg.sv]
// label flow check package: category widths, mode and verdict codes,
// membership bundle between the match stage and the top level
// no dependencies
`default_nettype none

package lfc_pkg;

    // category slot geometry
    localparam int unsigned CAT_W       = 8;
    localparam int unsigned MAX_SLOTS   = 8;
    localparam int unsigned SET_W       = CAT_W * MAX_SLOTS;
    localparam int unsigned SLOTS_DEF   = 8;
    localparam int unsigned CAT_TYPE_IX = CAT_W - 1;  // set: integrity, clear: secrecy

    // mode codes; bit 1 alone selects memory protection
    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_NO_OWN  = 2'd1;
    localparam logic [1:0] MODE_MEM     = 2'd2;
    localparam int unsigned MODE_MEM_IX = 1;

    // verdict codes
    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_FAIL = 2'd1;
    localparam logic [1:0] VERDICT_RW   = 2'd0;
    localparam logic [1:0] VERDICT_RO   = 2'd1;
    localparam logic [1:0] VERDICT_NONE = 2'd2;

    // per-slot flags and membership results of one word
    typedef struct packed {
        logic [MAX_SLOTS-1:0] sl_nz;
        logic [MAX_SLOTS-1:0] sl_int;
        logic [MAX_SLOTS-1:0] dl_nz;
        logic [MAX_SLOTS-1:0] dl_int;
        logic [MAX_SLOTS-1:0] dow_nz;
        logic [MAX_SLOTS-1:0] sl_in_so;
        logic [MAX_SLOTS-1:0] sl_in_dl;
        logic [MAX_SLOTS-1:0] dl_in_so;
        logic [MAX_SLOTS-1:0] dl_in_sl;
        logic [MAX_SLOTS-1:0] dow_in_so;
    } t_memb;

    // true when cat equals one of the first n slots of set
    function automatic logic is_member(input logic [SET_W-1:0] set,
                                       input logic [CAT_W-1:0] cat,
                                       input int unsigned      n);
        logic hit;
        hit = 1'b0;
        for (int unsigned j = 0; j < MAX_SLOTS; j++) begin
            if (j < n && set[j*CAT_W +: CAT_W] == cat) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

[hdl/lfc_match.sv]
// first pipeline stage: slot flags and all cross-set membership compares
// depends on lfc_pkg
`default_nettype none

module lfc_match import lfc_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [SET_W-1:0] i_source_label,
    input  wire logic [SET_W-1:0] i_source_owner,
    input  wire logic [SET_W-1:0] i_dest_label,
    input  wire logic [SET_W-1:0] i_dest_owner,
    output t_memb                 o_memb
);

    t_memb r_memb;
    t_memb n_memb;

    // compare every used slot against the other sets
    always_comb begin
        logic [CAT_W-1:0] sl_c;
        logic [CAT_W-1:0] dl_c;
        logic [CAT_W-1:0] dow_c;
        n_memb = '0;
        sl_c   = '0;
        dl_c   = '0;
        dow_c  = '0;
        for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
            if (i < SLOTS) begin
                sl_c  = i_source_label[i*CAT_W +: CAT_W];
                dl_c  = i_dest_label[i*CAT_W +: CAT_W];
                dow_c = i_dest_owner[i*CAT_W +: CAT_W];
                n_memb.sl_nz[i]     = |sl_c;
                n_memb.sl_int[i]    = sl_c[CAT_TYPE_IX];
                n_memb.dl_nz[i]     = |dl_c;
                n_memb.dl_int[i]    = dl_c[CAT_TYPE_IX];
                n_memb.dow_nz[i]    = |dow_c;
                n_memb.sl_in_so[i]  = is_member(i_source_owner, sl_c, SLOTS);
                n_memb.sl_in_dl[i]  = is_member(i_dest_label, sl_c, SLOTS);
                n_memb.dl_in_so[i]  = is_member(i_source_owner, dl_c, SLOTS);
                n_memb.dl_in_sl[i]  = is_member(i_source_label, dl_c, SLOTS);
                n_memb.dow_in_so[i] = is_member(i_source_owner, dow_c, SLOTS);
            end
        end
    end

    // stage register, payload only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_memb <= n_memb;
        end
    end

    assign o_memb = r_memb;

endmodule

`default_nettype wire

[hdl/label_flow_check_top.sv]
// label flow checker top level: three-stage pipeline with valid/ready
// depends on lfc_pkg and lfc_match
//
// usage
//   input channel: i_valid / o_ready carry one access word (mode and the
//   four category sets). output channel: o_valid / i_ready carry one
//   verdict word per access, in order.
//   stage 1 registers the slot compares (the 8x8 category comparator
//   arrays), stage 2 the write, read and ownership failure bits, stage 3
//   the verdict, which is the output register.
//   path: a word taken on the input passes the stage 1, stage 2 and stage 3
//   registers in order and shows on o_valid from the stage 3 register.
//   throughput: one word per cycle while i_ready is high; the comparator
//   arrays are fully parallel, so nothing is shared between words.
//   stall: when i_ready is low the output holds; each stage still fills if
//   it is empty, so up to three words sit in the pipe before o_ready drops.
//   no word is lost or repeated.
//   reset: synchronous, active low; clears all stage valid bits, so the
//   block is empty and o_ready is high on the first cycle after reset.
//   slots at or above SLOTS are ignored in every set.
`default_nettype none

module label_flow_check_top import lfc_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_mode,
    input  wire logic [SET_W-1:0] i_source_label,
    input  wire logic [SET_W-1:0] i_source_owner,
    input  wire logic [SET_W-1:0] i_dest_label,
    input  wire logic [SET_W-1:0] i_dest_owner,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [1:0]            o_verdict
);

    logic       r_s1_valid;
    logic       r_s2_valid;
    logic       r_s3_valid;
    logic [1:0] r_s1_mode;
    logic [1:0] r_s2_mode;
    logic       r_s2_wr_fail;
    logic       r_s2_rd_fail;
    logic       r_s2_own_fail;
    logic [1:0] r_s3_verdict;

    logic       s1_adv;
    logic       s2_adv;
    logic       s3_adv;
    t_memb      s1_memb;

    logic       n_wr_fail;
    logic       n_rd_fail;
    logic       n_own_fail;
    logic [1:0] n_verdict;

    // stall chain: a stage loads when it is empty or its word moves on
    assign s3_adv  = !r_s3_valid || i_ready;
    assign s2_adv  = !r_s2_valid || s3_adv;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;

    // stage 1: membership compares
    lfc_match #(
        .SLOTS (SLOTS)
    ) u_match (
        .i_clk          (i_clk),
        .i_en           (s1_adv),
        .i_source_label (i_source_label),
        .i_source_owner (i_source_owner),
        .i_dest_label   (i_dest_label),
        .i_dest_owner   (i_dest_owner),
        .o_memb         (s1_memb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_mode <= i_mode;
        end
    end

    // stage 2: per-slot rule failures reduced to write, read, ownership
    always_comb begin
        logic [MAX_SLOTS-1:0] sl_cover;
        logic [MAX_SLOTS-1:0] dl_cover;
        logic [MAX_SLOTS-1:0] sl_sec;
        logic [MAX_SLOTS-1:0] sl_itg;
        logic [MAX_SLOTS-1:0] dl_sec;
        logic [MAX_SLOTS-1:0] dl_itg;
        sl_cover   = s1_memb.sl_in_so | s1_memb.sl_in_dl;
        dl_cover   = s1_memb.dl_in_so | s1_memb.dl_in_sl;
        sl_sec     = s1_memb.sl_nz & ~s1_memb.sl_int;
        sl_itg     = s1_memb.sl_nz & s1_memb.sl_int;
        dl_sec     = s1_memb.dl_nz & ~s1_memb.dl_int;
        dl_itg     = s1_memb.dl_nz & s1_memb.dl_int;
        n_wr_fail  = |((sl_sec & ~sl_cover) | (dl_itg & ~dl_cover));
        n_rd_fail  = |((dl_sec & ~dl_cover) | (sl_itg & ~sl_cover));
        n_own_fail = |(s1_memb.dow_nz & ~s1_memb.dow_in_so);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_s2_mode     <= r_s1_mode;
            r_s2_wr_fail  <= n_wr_fail;
            r_s2_rd_fail  <= n_rd_fail;
            r_s2_own_fail <= n_own_fail;
        end
    end

    // stage 3: verdict encode
    always_comb begin
        if (r_s2_mode[MODE_MEM_IX]) begin
            if (!r_s2_rd_fail && !r_s2_wr_fail) begin
                n_verdict = VERDICT_RW;
            end else if (!r_s2_rd_fail) begin
                n_verdict = VERDICT_RO;
            end else begin
                n_verdict = VERDICT_NONE;
            end
        end else if (r_s2_wr_fail || (r_s2_mode == MODE_FULL && r_s2_own_fail)) begin
            n_verdict = VERDICT_FAIL;
        end else begin
            n_verdict = VERDICT_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_s3_verdict <= n_verdict;
        end
    end

    assign o_valid   = r_s3_valid;
    assign o_verdict = r_s3_verdict;

    // an empty first stage always takes a word
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_ready)
        else $error("input not ready with empty first stage");

    // a word in stage 2 reaches the output when the output can take it
    a_s2_moves : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && (!r_s3_valid || i_ready)) |=> o_valid)
        else $error("stage 2 word did not reach output");

    // memory-protection words only ever give the three defined codes
    a_mem_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && s3_adv && r_s2_mode == MODE_MEM) |=> o_verdict != 2'd3)
        else $error("undefined verdict code");

    // flow-check modes give pass or fail only
    a_flow_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && s3_adv && (r_s2_mode == MODE_FULL || r_s2_mode == MODE_NO_OWN))
        |=> (o_verdict == VERDICT_PASS || o_verdict == VERDICT_FAIL))
        else $error("flow check verdict out of range");

endmodule

`default_nettype wire
